/* hw/rtl/kpc_pkg.sv */
// Shared widths, register indexes, reset values and types of the key press classifier.
package kpc_pkg;

   localparam int unsigned KEY_FIELD_W = 3;
   localparam int unsigned NOW_W       = 32;
   localparam int unsigned TIME_W      = 16;
   localparam int unsigned CSR_IDX_W   = 8;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned REQ_DATA_W  = 40;
   localparam int unsigned RSP_DATA_W  = 8;

   localparam logic [CSR_IDX_W-1:0] REG_SHORT_TIME = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_TIME  = 8'd1;

   localparam logic [TIME_W-1:0] SHORT_TIME_RESET = 16'd50;
   localparam logic [TIME_W-1:0] LONG_TIME_RESET  = 16'd3000;

   typedef struct packed {
      logic [TIME_W-1:0] short_time;
      logic [TIME_W-1:0] long_time;
   } thresh_type;

   typedef struct packed {
      logic short_evt;
      logic long_evt;
   } key_evt_type;

endpackage

/* hw/rtl/kpc_key_cell.sv */
// Per-key press state machine: tracks idle, down and held-long, classifies releases and reports long holds.
module kpc_key_cell
   import kpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              pressed,
   input  logic [NOW_W-1:0]  now_ticks,
   input  thresh_type        thresh,
   output key_evt_type       evt
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DOWN,
      PH_HELD
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [NOW_W-1:0]  start_ff, start_in;
   logic [NOW_W-1:0]  elapsed;
   logic              reach_long;
   logic              reach_short;

   // Elapsed time wraps with the free-running timer.
   assign elapsed     = now_ticks - start_ff;
   assign reach_long  = elapsed >= {{(NOW_W-TIME_W){1'b0}}, thresh.long_time};
   assign reach_short = elapsed >= {{(NOW_W-TIME_W){1'b0}}, thresh.short_time};

   always_comb begin
      phase_in      = phase_ff;
      start_in      = start_ff;
      evt.short_evt = 1'b0;
      evt.long_evt  = 1'b0;
      case (phase_ff)
         PH_DOWN: begin
            if (!pressed) begin
               phase_in = PH_IDLE;
               if (reach_long) begin
                  evt.long_evt = 1'b1;
               end else if (reach_short) begin
                  evt.short_evt = 1'b1;
               end
            end else if (reach_long) begin
               phase_in     = PH_HELD;
               start_in     = now_ticks;
               evt.long_evt = 1'b1;
            end
         end
         PH_HELD: begin
            if (!pressed) begin
               phase_in = PH_IDLE;
            end else if (reach_long) begin
               start_in     = now_ticks;
               evt.long_evt = 1'b1;
            end
         end
         default: begin
            // A fresh press has zero elapsed time, so only a zero long threshold fires at once.
            phase_in = PH_IDLE;
            if (pressed) begin
               start_in = now_ticks;
               if (thresh.long_time == '0) begin
                  phase_in     = PH_HELD;
                  evt.long_evt = 1'b1;
               end else begin
                  phase_in = PH_DOWN;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (step) begin
         phase_ff <= phase_in;
      end
      if (step) begin
         start_ff <= start_in;
      end
   end

endmodule

/* hw/rtl/kpc_csr.sv */
// Threshold register file written through the configuration channel.
module kpc_csr
   import kpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output thresh_type             thresh
);

   thresh_type thresh_ff, thresh_in;

   assign csr_ready = 1'b1;
   assign thresh    = thresh_ff;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SHORT_TIME: thresh_in.short_time = csr_data;
            REG_LONG_TIME:  thresh_in.long_time  = csr_data;
            default:        thresh_in = thresh_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.short_time <= SHORT_TIME_RESET;
         thresh_ff.long_time  <= LONG_TIME_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

endmodule

/* hw/rtl/key_press_classifier_unit.sv */
// Top level of the key press classifier: input register, per-key cells and result register.
// A word accepted on req_ is held in the input stage, then evaluated by the key cells into the
// result stage and shown on rsp_. Throughput: one word per cycle while rsp_tready holds; each
// poll needs one 32-bit subtract and two compares per key.
// A new request word is taken while a result waits on rsp_ as long as the input stage is free;
// with both stages full, req_tready follows rsp_tready.
// Reset is synchronous and active high: every key returns to idle, both pipeline stages empty,
// and the thresholds reload to 50 ticks (short) and 3000 ticks (long).
module key_press_classifier_unit
   import kpc_pkg::*;
#(
   parameter int unsigned NUM_KEYS = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request words: pressed_mask [2:0], now_ticks [34:3], zero padding [39:35].
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // Result words: short_events [2:0], long_events [5:3], zero padding [7:6].
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // Threshold writes: index 0 is the short press time, index 1 the long press time.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Input stage holds one poll until the key cells evaluate it.
   logic                    in_valid_ff, in_valid_in;
   logic [KEY_FIELD_W-1:0]  in_mask_ff;
   logic [NOW_W-1:0]        in_now_ff;

   // Result stage holds the event masks until the consumer takes them.
   logic                    out_valid_ff, out_valid_in;
   logic [KEY_FIELD_W-1:0]  out_short_ff, out_long_ff;

   logic                    advance;
   logic                    step;
   logic                    req_fire;
   thresh_type              thresh;
   key_evt_type             key_evt [NUM_KEYS];
   logic [KEY_FIELD_W-1:0]  short_field, long_field;

   // The result stage frees up whenever it is empty or its word is being taken.
   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = step || (out_valid_ff && !rsp_tready);

   kpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .thresh    (thresh)
   );

   // Keys beyond the width of the mask field never see a press.
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
      logic key_pressed;
      if (k < KEY_FIELD_W) begin : g_wired
         assign key_pressed = in_mask_ff[k];
      end else begin : g_unwired
         assign key_pressed = 1'b0;
      end

      kpc_key_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      (step),
         .pressed   (key_pressed),
         .now_ticks (in_now_ff),
         .thresh    (thresh),
         .evt       (key_evt[k])
      );
   end

   // Only the keys that fit in the event fields are reported.
   for (genvar j = 0; j < KEY_FIELD_W; j++) begin : g_field
      if (j < NUM_KEYS) begin : g_live
         assign short_field[j] = key_evt[j].short_evt;
         assign long_field[j]  = key_evt[j].long_evt;
      end else begin : g_dead
         assign short_field[j] = 1'b0;
         assign long_field[j]  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_fire) begin
         in_mask_ff <= req_tdata[KEY_FIELD_W-1:0];
         in_now_ff  <= req_tdata[KEY_FIELD_W +: NOW_W];
      end
      if (step) begin
         out_short_ff <= short_field;
         out_long_ff  <= long_field;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2*KEY_FIELD_W){1'b0}}, out_long_ff, out_short_ff};

endmodule

/* hw/rtl/kpc_checker.sv */
// Port-level checks of the key press classifier and the bind that attaches them.
module kpc_checker
   import kpc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata
);

   // A stalled result word keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // One release or hold cannot give both a short and a long event for the same key.
   a_evt_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[KEY_FIELD_W-1:0] & rsp_tdata[2*KEY_FIELD_W-1:KEY_FIELD_W]) == '0))
      else $error("short and long event on the same key");

   // With the result stage empty the input side is never blocked.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked while no result is pending");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result word present right after reset");

endmodule

bind key_press_classifier_unit kpc_checker u_kpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
